>>> rtl/sedd_pkg.sv
// ----------------------------------------------------------------------------
// Serpentine error diffusion dither package
// Shared widths, register indexes, reset values, state codes and the
// saturating arithmetic used by the halftoning datapath.
// ----------------------------------------------------------------------------
package sedd_pkg;

   localparam int PIX_W        = 8;
   localparam int ERR_W        = 16;
   localparam int ACC_W        = 24;
   localparam int ROW_W        = 12;
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int THRESH_W     = 8;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 2;
   localparam int MAX_HEIGHT   = 4096;
   localparam int SIXTEENTH_BITS = 4;

   typedef logic signed [ERR_W-1:0] err_type;
   typedef logic [1:0][ERR_W-1:0]   err_pair_type;
   typedef logic [CSR_INDEX_W-1:0]  csr_index_type;

   localparam csr_index_type REG_IMAGE_WIDTH  = 2'd0;
   localparam csr_index_type REG_IMAGE_HEIGHT = 2'd1;
   localparam csr_index_type REG_THRESHOLD    = 2'd2;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd1280;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd795;
   localparam logic [THRESH_W-1:0]     THRESH_RESET = 8'd128;

   localparam logic [PIX_W-1:0] PIX_FULL  = 8'd255;
   localparam logic [PIX_W-1:0] PIX_INK   = 8'd0;
   localparam logic [PIX_W-1:0] PIX_BLANK = 8'd255;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_FL_A  = 7'b0000010,
      ST_FL_B  = 7'b0000100,
      ST_PRE_A = 7'b0001000,
      ST_PRE_B = 7'b0010000,
      ST_PRE_C = 7'b0100000,
      ST_RUN   = 7'b1000000
   } state_type;

   function automatic err_type sat_err(input logic signed [ACC_W-1:0] v);
      if (v > ACC_W'(32767)) begin
         return 16'sh7FFF;
      end else if (v < ACC_W'(-32768)) begin
         return 16'sh8000;
      end
      return v[ERR_W-1:0];
   endfunction

   function automatic err_type add_sat(input logic [ERR_W-1:0] prev,
                                       input logic signed [ACC_W-1:0] amount);
      return sat_err(ACC_W'($signed(prev)) + amount);
   endfunction

endpackage

>>> rtl/sedd_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; the read data holds its value
// when no read is issued.
// ----------------------------------------------------------------------------
module sedd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_en,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_en) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

>>> rtl/serpentine_error_diffusion_dither_core.sv
// ----------------------------------------------------------------------------
// Serpentine Floyd-Steinberg error diffusion halftoner: result registered on accept.
// One pixel per cycle in a row unless the output stalls; each row end flushes and reloads.
// Reset clears the row buffer word by word, during which no pixel is taken.
// ----------------------------------------------------------------------------
module serpentine_error_diffusion_dither_core #(
   parameter int MAX_WIDTH = 2048,
   parameter int FRAC_BITS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sedd_pkg::PIX_W-1:0]        req_pixel_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sedd_pkg::PIX_W-1:0]        rsp_pixel_out,
   output logic                              rsp_plane_done,
   input  logic                              csr_write_en,
   input  logic [sedd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sedd_pkg::CSR_DATA_W-1:0]   csr_data
);

   import sedd_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int WW = XW + 1;
   localparam int UNIT_SHIFT = FRAC_BITS - SIXTEENTH_BITS;
   localparam logic [XW-1:0] CLR_LAST = XW'(MAX_WIDTH - 1);

   state_type state_ff, state_in;
   logic [XW-1:0] clr_ff, clr_in;
   logic [WIDTH_REG_W-1:0] width_ff, width_in;
   logic [HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [THRESH_W-1:0] thresh_ff, thresh_in;
   logic [XW-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   err_type carry_ff, carry_in;
   err_pair_type a_word_ff, a_word_in, b_word_ff, b_word_in;
   logic [XW-1:0] a_pos_ff, a_pos_in, b_pos_ff, b_pos_in, c_pos_ff, c_pos_in;
   logic a_vld_ff, a_vld_in, b_vld_ff, b_vld_in, c_vld_ff, c_vld_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic rsp_done_ff, rsp_done_in;

   logic [WW-1:0] w_eff, col_eff, col_m1, col_p1, col_p2;
   logic [HEIGHT_REG_W-1:0] h_eff, row_eff;
   logic odd_row, cb, nb, last_col, last_row, req_accept;
   logic [XW-1:0] pos_m1, pos_0, pos_p1, pos_p2;
   err_type cur_err, v_err;
   logic [PIX_W-1:0] pix_inv;
   logic signed [ACC_W-1:0] base_q, sum_q, v_q, thr_q, full_q, err_q, e_q, unit_q;
   logic signed [ACC_W-1:0] part3_q, part5_q, part7_q;
   logic ink;
   err_pair_type a_upd, b_upd, c_word, c_upd;

   logic ram_we, ram_re;
   logic [XW-1:0] ram_waddr, ram_raddr;
   err_pair_type ram_wdata;
   logic [2*ERR_W-1:0] ram_rdata;

   function automatic logic [XW-1:0] pos_of(input logic [WW-1:0] c, input logic odd,
                                            input logic [WW-1:0] w);
      logic [WW-1:0] mir;
      mir = w - c - WW'(1);
      return odd ? c[XW-1:0] : mir[XW-1:0];
   endfunction

   sedd_ram #(
      .WIDTH(2 * ERR_W),
      .DEPTH(MAX_WIDTH)
   ) u_row_buf (
      .clock(clock),
      .write_en(ram_we),
      .write_addr(ram_waddr),
      .write_data(ram_wdata),
      .read_en(ram_re),
      .read_addr(ram_raddr),
      .read_data(ram_rdata)
   );

   assign req_stall = (state_ff != ST_RUN) | (rsp_valid_ff & rsp_stall);
   assign req_accept = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_plane_done = rsp_done_ff;

   // Effective geometry and position in the serpentine scan.
   always_comb begin
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HEIGHT_REG_W'(1);
      end else if (height_ff > HEIGHT_REG_W'(MAX_HEIGHT)) begin
         h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      col_eff = (WW'(col_ff) >= w_eff) ? w_eff - WW'(1) : WW'(col_ff);
      row_eff = (HEIGHT_REG_W'(row_ff) >= h_eff) ? h_eff - HEIGHT_REG_W'(1)
                                                 : HEIGHT_REG_W'(row_ff);
      col_m1 = col_eff - WW'(1);
      col_p1 = col_eff + WW'(1);
      col_p2 = col_eff + WW'(2);
      odd_row = row_eff[0];
      cb = row_eff[0];
      nb = ~row_eff[0];
      last_col = (col_p1 == w_eff);
      last_row = (row_eff + HEIGHT_REG_W'(1) == h_eff);
      pos_m1 = pos_of(col_m1, odd_row, w_eff);
      pos_0  = pos_of(col_eff, odd_row, w_eff);
      pos_p1 = pos_of(col_p1, odd_row, w_eff);
      pos_p2 = pos_of(col_p2, odd_row, w_eff);
   end

   // Threshold, quantization error and the diffusion shares.
   always_comb begin
      cur_err = b_word_ff[cb];
      pix_inv = PIX_FULL - req_pixel_in;
      base_q = $signed(ACC_W'(pix_inv)) <<< FRAC_BITS;
      sum_q = base_q + ACC_W'(cur_err) + ACC_W'(carry_ff);
      v_err = sat_err(sum_q);
      v_q = ACC_W'(v_err);
      thr_q = $signed(ACC_W'(thresh_ff)) <<< FRAC_BITS;
      full_q = $signed(ACC_W'(PIX_FULL)) <<< FRAC_BITS;
      ink = v_q > thr_q;
      err_q = ink ? v_q - full_q : v_q;
      e_q = err_q >>> FRAC_BITS;
      if (err_q[ACC_W-1] && (|err_q[FRAC_BITS-1:0])) begin
         e_q = e_q + ACC_W'(1);
      end
      unit_q = e_q <<< UNIT_SHIFT;
      part3_q = (unit_q <<< 1) + unit_q;
      part5_q = (unit_q <<< 2) + unit_q;
      part7_q = (unit_q <<< 3) - unit_q;

      c_word = ram_rdata;
      a_upd = a_word_ff;
      b_upd = b_word_ff;
      c_upd = c_word;
      b_upd[cb] = '0;
      if (!last_row) begin
         a_upd[nb] = add_sat(a_word_ff[nb], part3_q);
         b_upd[nb] = add_sat(b_word_ff[nb], part5_q);
         c_upd[nb] = add_sat(c_word[nb], unit_q);
      end
   end

   // Sequencer, row-buffer port and state updates.
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      width_in = width_ff;
      height_in = height_ff;
      thresh_in = thresh_ff;
      col_in = col_ff;
      row_in = row_ff;
      carry_in = carry_ff;
      a_word_in = a_word_ff;
      b_word_in = b_word_ff;
      a_pos_in = a_pos_ff;
      b_pos_in = b_pos_ff;
      c_pos_in = c_pos_ff;
      a_vld_in = a_vld_ff;
      b_vld_in = b_vld_ff;
      c_vld_in = c_vld_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_done_in = rsp_done_ff;
      ram_we = 1'b0;
      ram_waddr = a_pos_ff;
      ram_wdata = a_upd;
      ram_re = 1'b0;
      ram_raddr = pos_p2;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in = clr_ff + XW'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = ST_PRE_A;
            end
         end
         ST_FL_A: begin
            ram_we = a_vld_ff;
            ram_wdata = a_word_ff;
            a_vld_in = 1'b0;
            state_in = ST_FL_B;
         end
         ST_FL_B: begin
            ram_we = b_vld_ff;
            ram_waddr = b_pos_ff;
            ram_wdata = b_word_ff;
            b_vld_in = 1'b0;
            state_in = ST_PRE_A;
         end
         ST_PRE_A: begin
            ram_re = 1'b1;
            ram_raddr = pos_m1;
            a_pos_in = pos_m1;
            a_vld_in = (col_eff != '0);
            state_in = csr_write_en ? ST_PRE_A : ST_PRE_B;
         end
         ST_PRE_B: begin
            a_word_in = c_word;
            ram_re = 1'b1;
            ram_raddr = pos_0;
            b_pos_in = pos_0;
            state_in = csr_write_en ? ST_PRE_A : ST_PRE_C;
         end
         ST_PRE_C: begin
            b_word_in = c_word;
            b_vld_in = 1'b1;
            ram_re = 1'b1;
            ram_raddr = pos_p1;
            c_pos_in = pos_p1;
            c_vld_in = (col_p1 < w_eff);
            state_in = csr_write_en ? ST_PRE_A : ST_RUN;
         end
         ST_RUN: begin
            if (csr_write_en) begin
               state_in = ST_FL_A;
            end else if (req_accept) begin
               ram_we = a_vld_ff;
               ram_re = 1'b1;
               a_word_in = b_upd;
               a_pos_in = b_pos_ff;
               a_vld_in = 1'b1;
               b_word_in = c_upd;
               b_pos_in = c_pos_ff;
               b_vld_in = c_vld_ff;
               c_pos_in = pos_p2;
               c_vld_in = (col_p2 < w_eff);
               rsp_valid_in = 1'b1;
               rsp_pixel_in = ink ? PIX_INK : PIX_BLANK;
               rsp_done_in = last_col & last_row;
               if (last_col) begin
                  state_in = ST_FL_A;
                  col_in = '0;
                  carry_in = '0;
                  row_in = last_row ? '0 : ROW_W'(row_eff + HEIGHT_REG_W'(1));
               end else begin
                  col_in = col_p1[XW-1:0];
                  carry_in = sat_err(part7_q);
                  row_in = ROW_W'(row_eff);
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      if (csr_write_en) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_in = csr_data[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_in = csr_data[HEIGHT_REG_W-1:0];
            REG_THRESHOLD:    thresh_in = csr_data[THRESH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         width_ff <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         thresh_ff <= THRESH_RESET;
         col_ff <= '0;
         row_ff <= '0;
         carry_ff <= '0;
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         width_ff <= width_in;
         height_ff <= height_in;
         thresh_ff <= thresh_in;
         col_ff <= col_in;
         row_ff <= row_in;
         carry_ff <= carry_in;
         a_vld_ff <= a_vld_in;
         b_vld_ff <= b_vld_in;
         c_vld_ff <= c_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_word_ff <= a_word_in;
      b_word_ff <= b_word_in;
      a_pos_ff <= a_pos_in;
      b_pos_ff <= b_pos_in;
      c_pos_ff <= c_pos_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_done_ff <= rsp_done_in;
   end

`ifndef ASSERT_OFF
   a_run_has_pixel_word: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> b_vld_ff)
      else $error("Window holds no word for the current pixel while running.");

   a_window_distinct: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && a_vld_ff) |-> a_pos_ff != b_pos_ff)
      else $error("Two window entries map to the same row-buffer word.");

   a_port_no_collision: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> ram_waddr != ram_raddr)
      else $error("Row-buffer read and write hit the same word in one cycle.");

   a_row_end_flush: assert property (@(posedge clock) disable iff (reset)
      (req_accept && last_col) |=> state_ff == ST_FL_A)
      else $error("Row end did not start a window flush.");
`endif

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// Serpentine error diffusion dither core testbench
// Drives pixel transactions through the halftoner and compares every result
// with a cycle-free model of the serpentine Floyd-Steinberg datapath. A short
// directed table covers reset values, threshold and geometry extremes and
// shrinking the image mid-plane. Random planes of mostly small geometry follow,
// with bursty input, random output stalls and long output hold-offs.
// ----------------------------------------------------------------------------
module testbench;
   import sedd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W         = 2048;
   localparam int FRAC          = 4;
   localparam int ONE_Q         = 1 << FRAC;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_ITEMS  = 1800;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DIRECTED_LEN  = 36;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             done;
   } halftone_t;

   typedef enum logic {
      ENTRY_PIXEL,
      ENTRY_WRITE
   } entry_kind_e;

   typedef struct packed {
      entry_kind_e          kind;
      csr_index_type        idx;
      logic [CSR_DATA_W-1:0] value;
      logic                 typed;
      logic [PIX_W-1:0]     exp_pixel;
      logic                 exp_done;
   } directed_entry_t;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [PIX_W-1:0]       req_pixel_in;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [PIX_W-1:0]       rsp_pixel_out;
   logic                   rsp_plane_done;
   logic                   csr_write_en;
   csr_index_type          csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // Mirror of the halftoner state and registers.
   err_type                  pending_err [2*MAX_W];
   err_type                  carry_err;
   int                       row_idx;
   int                       col_idx;
   logic [WIDTH_REG_W-1:0]   width_reg;
   logic [HEIGHT_REG_W-1:0]  height_reg;
   logic [THRESH_W-1:0]      threshold_reg;

   halftone_t halftone_queue [$];

   int cycle_count        = 0;
   int input_stall_cycles = 0;
   int pixels_sent        = 0;
   int results_seen       = 0;
   int planes_done        = 0;
   int error_count        = 0;
   int reg_writes         = 0;
   int hold_offs          = 0;
   int burst_left         = 0;

   directed_entry_t directed_entries [DIRECTED_LEN] = '{
      '{ENTRY_PIXEL, REG_IMAGE_WIDTH,  13'd0,    1'b1, PIX_INK,   1'b0},
      '{ENTRY_PIXEL, REG_IMAGE_WIDTH,  13'd255,  1'b1, PIX_BLANK, 1'b0},
      '{ENTRY_PIXEL, REG_IMAGE_WIDTH,  13'd255,  1'b1, PIX_BLANK, 1'b0},
      '{ENTRY_PIXEL, REG_IMAGE_WIDTH,  13'd0,    1'b1, PIX_INK,   1'b0},
      '{ENTRY_PIXEL, REG_IMAGE_WIDTH,  13'd128,  1'b0, PIX_INK,   1'b0},
      '{ENTRY_PIXEL, REG_IMAGE_WIDTH,  13'd127,  1'b0, PIX_INK,   1'b0},
      '{ENTRY_WRITE, REG_IMAGE_WIDTH,  13'd3,    1'b0, PIX_INK,   1'b0},
      '{ENTRY_WRITE, REG_IMAGE_HEIGHT, 13'd2,    1'b0, PIX_INK,   1'b0},
      '{ENTRY_PIXEL, REG_IMAGE_WIDTH,  13'd200,  1'b0, PIX_INK,   1'b0},
      '{ENTRY_PIXEL, REG_IMAGE_WIDTH,  13'd30,   1'b0, PIX_INK,   1'b0},
      '{ENTRY_PIXEL, REG_IMAGE_WIDTH,  13'd90,   1'b0, PIX_INK,   1'b0},
      '{ENTRY_PIXEL, REG_IMAGE_WIDTH,  13'd255,  1'b0, PIX_INK,   1'b0},
      '{ENTRY_PIXEL, REG_IMAGE_WIDTH,  13'd60,   1'b0, PIX_INK,   1'b0},
      '{ENTRY_WRITE, REG_THRESHOLD,    13'd0,    1'b0, PIX_INK,   1'b0},
      '{ENTRY_WRITE, REG_IMAGE_WIDTH,  13'd0,    1'b0, PIX_INK,   1'b0},
      '{ENTRY_WRITE, REG_IMAGE_HEIGHT, 13'd0,    1'b0, PIX_INK,   1'b0},
      '{ENTRY_PIXEL, REG_IMAGE_WIDTH,  13'd255,  1'b0, PIX_INK,   1'b0},
      '{ENTRY_PIXEL, REG_IMAGE_WIDTH,  13'd0,    1'b1, PIX_INK,   1'b1},
      '{ENTRY_PIXEL, REG_IMAGE_WIDTH,  13'd255,  1'b1, PIX_BLANK, 1'b1},
      '{ENTRY_PIXEL, REG_IMAGE_WIDTH,  13'd254,  1'b1, PIX_INK,   1'b1},
      '{ENTRY_WRITE, REG_THRESHOLD,    13'd255,  1'b0, PIX_INK,   1'b0},
      '{ENTRY_WRITE, REG_IMAGE_WIDTH,  13'd4095, 1'b0, PIX_INK,   1'b0},
      '{ENTRY_WRITE, REG_IMAGE_HEIGHT, 13'd8191, 1'b0, PIX_INK,   1'b0},
      '{ENTRY_PIXEL, REG_IMAGE_WIDTH,  13'd0,    1'b1, PIX_BLANK, 1'b0},
      '{ENTRY_PIXEL, REG_IMAGE_WIDTH,  13'd0,    1'b0, PIX_INK,   1'b0},
      '{ENTRY_PIXEL, REG_IMAGE_WIDTH,  13'd255,  1'b0, PIX_INK,   1'b0},
      '{ENTRY_PIXEL, REG_IMAGE_WIDTH,  13'd0,    1'b0, PIX_INK,   1'b0},
      '{ENTRY_WRITE, REG_IMAGE_WIDTH,  13'd2,    1'b0, PIX_INK,   1'b0},
      '{ENTRY_WRITE, REG_IMAGE_HEIGHT, 13'd3,    1'b0, PIX_INK,   1'b0},
      '{ENTRY_WRITE, REG_THRESHOLD,    13'd128,  1'b0, PIX_INK,   1'b0},
      '{ENTRY_PIXEL, REG_IMAGE_WIDTH,  13'd10,   1'b0, PIX_INK,   1'b0},
      '{ENTRY_PIXEL, REG_IMAGE_WIDTH,  13'd240,  1'b0, PIX_INK,   1'b0},
      '{ENTRY_PIXEL, REG_IMAGE_WIDTH,  13'd128,  1'b0, PIX_INK,   1'b0},
      '{ENTRY_PIXEL, REG_IMAGE_WIDTH,  13'd129,  1'b0, PIX_INK,   1'b0},
      '{ENTRY_PIXEL, REG_IMAGE_WIDTH,  13'd64,   1'b0, PIX_INK,   1'b0},
      '{ENTRY_PIXEL, REG_IMAGE_WIDTH,  13'd192,  1'b0, PIX_INK,   1'b0}
   };

   serpentine_error_diffusion_dither_core #(
      .MAX_WIDTH (MAX_W),
      .FRAC_BITS (FRAC)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_plane_done (rsp_plane_done),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic err_type clamp16(input int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return err_type'(v);
   endfunction

   function automatic int effective_width();
      if (width_reg == '0) return 1;
      if (int'(width_reg) > MAX_W) return MAX_W;
      return int'(width_reg);
   endfunction

   function automatic int effective_height();
      if (height_reg == '0) return 1;
      if (int'(height_reg) > MAX_HEIGHT) return MAX_HEIGHT;
      return int'(height_reg);
   endfunction

   function automatic void spread_error(input int bank, input int x, input int w,
                                        input int amount);
      int idx;
      if (x < 0 || x >= w) return;
      idx = bank * MAX_W + x;
      pending_err[idx] = clamp16(int'(pending_err[idx]) + amount);
   endfunction

   function automatic halftone_t predict_halftone(input logic [PIX_W-1:0] pix);
      int w;
      int h;
      int x;
      int cur;
      int idx;
      int v;
      int err_q;
      int e_scaled;
      int dir_sign;
      bit ink;
      bit last_col;
      bit last_row;
      halftone_t res;
      w = effective_width();
      h = effective_height();
      if (col_idx >= w) col_idx = w - 1;
      if (row_idx >= h) row_idx = h - 1;
      x = row_idx[0] ? col_idx : w - 1 - col_idx;
      cur = row_idx & 1;
      idx = cur * MAX_W + x;
      v = (255 - int'(pix)) * ONE_Q + int'(pending_err[idx]) + int'(carry_err);
      v = int'(clamp16(v));
      pending_err[idx] = '0;
      ink = v > int'(threshold_reg) * ONE_Q;
      err_q = ink ? v - 255 * ONE_Q : v;
      e_scaled = (err_q / ONE_Q) * (ONE_Q / 16);
      last_col = (col_idx == w - 1);
      last_row = (row_idx == h - 1);
      carry_err = last_col ? err_type'(0) : clamp16(7 * e_scaled);
      if (!last_row) begin
         dir_sign = row_idx[0] ? 1 : -1;
         spread_error(cur ^ 1, x - dir_sign, w, 3 * e_scaled);
         spread_error(cur ^ 1, x, w, 5 * e_scaled);
         spread_error(cur ^ 1, x + dir_sign, w, e_scaled);
      end
      res.pixel = ink ? PIX_INK : PIX_BLANK;
      res.done = last_col && last_row;
      if (last_col) begin
         col_idx = 0;
         carry_err = '0;
         row_idx = last_row ? 0 : row_idx + 1;
      end else begin
         col_idx++;
      end
      return res;
   endfunction

   task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit typed,
                             input halftone_t typed_res);
      halftone_t predicted;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 40);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_halftone(pix);
      halftone_queue.push_back(typed ? typed_res : predicted);
      pixels_sent++;
      burst_left--;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      req_valid <= 1'b0;
      while (halftone_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         REG_IMAGE_WIDTH:  width_reg = value[WIDTH_REG_W-1:0];
         REG_IMAGE_HEIGHT: height_reg = value[HEIGHT_REG_W-1:0];
         REG_THRESHOLD:    threshold_reg = value[THRESH_W-1:0];
         default: ;
      endcase
      reg_writes++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (req_valid && req_stall) begin
         input_stall_cycles <= input_stall_cycles + 1;
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding.", cycle_count,
                  halftone_queue.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      halftone_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (halftone_queue.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("Unexpected transaction: pixel_out %0d plane_done %0b",
                        rsp_pixel_out, rsp_plane_done);
            end
         end else begin
            want = halftone_queue.pop_front();
            if (want.done) planes_done++;
            if (rsp_pixel_out !== want.pixel || rsp_plane_done !== want.done) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("Mismatch on result %0d: expected pixel_out %0d plane_done %0b, got %0d %0b",
                           results_seen, want.pixel, want.done, rsp_pixel_out,
                           rsp_plane_done);
               end
            end
         end
      end
   end

   initial begin
      int mode;
      int k;
      rsp_stall <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (hold_offs < 2 && pixels_sent >= (hold_offs + 1) * 700) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_offs++;
         end
         mode = $urandom_range(0, 3);
         k = 0;
         repeat ($urandom_range(5, 60)) begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 1) == 1);
               2: rsp_stall <= ($urandom_range(0, 4) == 0);
               default: rsp_stall <= (k % 3 == 0);
            endcase
            k++;
            @(posedge clock);
         end
      end
   end

   initial begin
      int random_sent;
      int phase_len;
      int eff_w;
      int eff_h;
      int cur_col;
      int cur_row;
      int remaining;
      int style;
      int level;
      int p;
      int geo_pick;
      bit first_phase;
      logic [WIDTH_REG_W-1:0]  new_w;
      logic [HEIGHT_REG_W-1:0] new_h;
      logic [THRESH_W-1:0]     new_t;

      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_pixel_in <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= REG_IMAGE_WIDTH;
      csr_data     <= '0;
      foreach (pending_err[i]) pending_err[i] = '0;
      carry_err     = '0;
      row_idx       = 0;
      col_idx       = 0;
      width_reg     = WIDTH_RESET;
      height_reg    = HEIGHT_RESET;
      threshold_reg = THRESH_RESET;
      burst_left    = 20;
      random_sent   = 0;
      first_phase   = 1'b1;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_entries[i]) begin
         if (directed_entries[i].kind == ENTRY_WRITE) begin
            write_reg(directed_entries[i].idx, directed_entries[i].value);
         end else begin
            send_pixel(directed_entries[i].value[PIX_W-1:0], directed_entries[i].typed,
                       halftone_t'{directed_entries[i].exp_pixel, directed_entries[i].exp_done});
         end
      end

      while (random_sent < RANDOM_ITEMS) begin
         geo_pick = $urandom_range(0, 9);
         if (geo_pick < 6) begin
            new_w = WIDTH_REG_W'($urandom_range(1, 24));
            new_h = HEIGHT_REG_W'($urandom_range(1, 12));
         end else if (geo_pick < 8) begin
            new_w = WIDTH_REG_W'($urandom_range(25, 300));
            new_h = HEIGHT_REG_W'($urandom_range(1, 6));
         end else if (geo_pick == 8) begin
            new_w = WIDTH_REG_W'($urandom_range(0, 4095));
            new_h = HEIGHT_REG_W'($urandom_range(0, 8191));
         end else begin
            new_w = ($urandom_range(0, 1) == 1) ? '1 : '0;
            new_h = ($urandom_range(0, 1) == 1) ? '1 : '0;
         end
         case ($urandom_range(0, 3))
            0: new_t = THRESH_W'($urandom_range(0, 255));
            1: new_t = ($urandom_range(0, 1) == 1) ? '1 : '0;
            default: new_t = THRESH_W'($urandom_range(96, 160));
         endcase
         if (first_phase || $urandom_range(0, 2) != 0) write_reg(REG_IMAGE_WIDTH, {1'b0, new_w});
         if (first_phase || $urandom_range(0, 2) != 0) write_reg(REG_IMAGE_HEIGHT, new_h);
         if (first_phase || $urandom_range(0, 2) != 0) write_reg(REG_THRESHOLD, {5'd0, new_t});
         first_phase = 1'b0;

         eff_w = effective_width();
         eff_h = effective_height();
         cur_col = (col_idx >= eff_w) ? eff_w - 1 : col_idx;
         cur_row = (row_idx >= eff_h) ? eff_h - 1 : row_idx;
         remaining = eff_w * eff_h - (cur_row * eff_w + cur_col);
         if ($urandom_range(0, 9) < 7) begin
            phase_len = remaining;
            if ($urandom_range(0, 2) == 0) phase_len += eff_w * eff_h;
            if (phase_len > 400) phase_len = $urandom_range(40, 300);
         end else begin
            phase_len = $urandom_range(1, 40);
         end

         style = $urandom_range(0, 3);
         level = $urandom_range(0, 255);
         repeat (phase_len) begin
            case (style)
               0: p = $urandom_range(0, 255);
               1: p = level + int'($urandom_range(0, 6)) - 3;
               2: p = ($urandom_range(0, 1) == 1) ? 255 : 0;
               default: p = 255 - int'(threshold_reg) + int'($urandom_range(0, 4)) - 2;
            endcase
            if ($urandom_range(0, 19) == 0) p = $urandom_range(0, 255);
            p = (p < 0) ? 0 : ((p > 255) ? 255 : p);
            send_pixel(PIX_W'(p), 1'b0, '0);
            random_sent++;
         end
      end

      req_valid <= 1'b0;
      while (halftone_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d pixels and checked %0d results over %0d register writes, %0d planes completed.",
               pixels_sent, results_seen, reg_writes, planes_done);
      $display("Input held off for %0d cycles, with %0d long output hold-offs.",
               input_stall_cycles, hold_offs);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d failing transactions in total.", error_count);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> serpentine_error_diffusion_dither_core.f
rtl/sedd_pkg.sv
rtl/sedd_ram.sv
rtl/serpentine_error_diffusion_dither_core.sv
verif/testbench.sv
